[hdl/pau_pkg.sv]
// Shared types, codes and helpers of the polynomial arithmetic unit.
// No dependencies.
package pau_pkg;

    localparam int OPERAND_TERMS_DEF = 32;
    localparam int RESULT_TERMS_DEF  = 64;
    localparam int FRAC_BITS_DEF     = 16;

    localparam int COEFF_W = 32;
    localparam int TERM_W  = 6;
    localparam int ERR_W   = 2;
    localparam int MODE_W  = 3;
    localparam int EXP_W   = 6;
    localparam int CFG_AW  = 2;

    // command word fields sized for the largest operand store
    localparam int CMD_AW    = 8;
    localparam int CMD_LW    = 9;
    localparam int CMD_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MUL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SCALE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POW   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_LONG = 2'd2;

    localparam logic [CFG_AW-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_AW-1:0] REG_SCALAR   = 2'd1;
    localparam logic [CFG_AW-1:0] REG_EXPONENT = 2'd2;

    typedef struct packed {
        logic                wr;
        logic                sel;
        logic [CMD_AW-1:0]   addr;
        logic [COEFF_W-1:0]  data;
        logic                run;
        logic [CMD_LW-1:0]   nza;
        logic [CMD_LW-1:0]   nzb;
    } pau_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } pau_fifo_st_t;

    typedef struct packed {
        logic busy;
        logic pop;
    } pau_back_st_t;

    function automatic logic [COEFF_W-1:0] sat32(input logic signed [63:0] v);
        logic [COEFF_W-1:0] r;
        if (v > 64'sh000000007FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -64'sh0000000080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[COEFF_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/pau_front.sv]
// Input side: tracks operand lengths and trimmed lengths, turns each word
// into a store/run command. Depends on pau_pkg.
module pau_front
    import pau_pkg::*;
#(
    parameter int OPERAND_TERMS = OPERAND_TERMS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic               in_sel,
    input  logic [COEFF_W-1:0] in_coeff,
    input  logic               in_last,
    input  logic [MODE_W-1:0]  mode,
    input  pau_fifo_st_t       fifo_st,
    output logic               push,
    output pau_cmd_t           cmd
);

    localparam int OLW = $clog2(OPERAND_TERMS + 1);

    logic [OLW-1:0] a_len_reg, b_len_reg, a_nz_reg, b_nz_reg;
    logic           a_closed_reg, b_closed_reg;
    logic [OLW-1:0] cur_len, cur_nz, new_len, new_nz;
    logic           accept, wr, run;

    always_comb begin
        cur_len = in_sel ? b_len_reg : a_len_reg;
        cur_nz  = in_sel ? b_nz_reg : a_nz_reg;
        if (in_sel ? b_closed_reg : a_closed_reg) begin
            cur_len = '0;
            cur_nz  = '0;
        end
        wr      = cur_len < OLW'(OPERAND_TERMS);
        new_len = wr ? cur_len + OLW'(1) : cur_len;
        new_nz  = (wr && in_coeff != '0) ? cur_len + OLW'(1) : cur_nz;
        if (in_sel) begin
            run = in_last && (mode == MODE_ADD || mode == MODE_SUB || mode == MODE_MUL);
        end else begin
            run = in_last && (mode == MODE_SCALE || mode == MODE_DIV || mode == MODE_POW);
        end
    end

    assign s_tready = !fifo_st.full;
    assign accept   = s_tvalid && !fifo_st.full;
    assign push     = accept && (wr || run);

    always_comb begin
        cmd      = '0;
        cmd.wr   = wr;
        cmd.sel  = in_sel;
        cmd.addr = CMD_AW'(cur_len);
        cmd.data = in_coeff;
        cmd.run  = run;
        cmd.nza  = CMD_LW'(in_sel ? a_nz_reg : new_nz);
        cmd.nzb  = CMD_LW'(in_sel ? new_nz : b_nz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_len_reg    <= '0;
            b_len_reg    <= '0;
            a_nz_reg     <= '0;
            b_nz_reg     <= '0;
            a_closed_reg <= 1'b0;
            b_closed_reg <= 1'b0;
        end else if (accept) begin
            if (in_sel) begin
                b_len_reg    <= new_len;
                b_nz_reg     <= new_nz;
                b_closed_reg <= in_last;
            end else begin
                a_len_reg    <= new_len;
                a_nz_reg     <= new_nz;
                a_closed_reg <= in_last;
            end
        end
    end

endmodule

[hdl/pau_cmd_fifo.sv]
// Short command queue between front and back.
// Depends on pau_pkg.
module pau_cmd_fifo
    import pau_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  pau_cmd_t     push_cmd,
    input  logic         pop,
    output pau_cmd_t     head,
    output pau_fifo_st_t st
);

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CNW = $clog2(CMD_DEPTH + 1);

    pau_cmd_t       mem_reg [CMD_DEPTH];
    logic [PW-1:0]  wptr_reg, rptr_reg;
    logic [CNW-1:0] count_reg;

    assign head     = mem_reg[rptr_reg];
    assign st.empty = count_reg == '0;
    assign st.full  = count_reg == CNW'(CMD_DEPTH);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
            end
            count_reg <= count_reg + CNW'(push) - CNW'(pop);
        end
    end

endmodule

[hdl/pau_div.sv]
// Bit-serial signed divider: (dividend << FRAC_BITS) / divisor, truncated
// toward zero, saturated to 32 bits. Depends on pau_pkg.
module pau_div
    import pau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COEFF_W-1:0] dividend,
    input  logic [COEFF_W-1:0] divisor,
    output logic               done,
    output logic [COEFF_W-1:0] quotient
);

    localparam int DW  = COEFF_W + FRAC_BITS;
    localparam int QCW = $clog2(DW + 1);

    logic [COEFF_W:0]   rem_reg;
    logic [DW-1:0]      quo_reg;
    logic [COEFF_W-1:0] dmag_reg;
    logic [QCW-1:0]     cnt_reg;
    logic               busy_reg, neg_reg, done_reg;
    logic [COEFF_W-1:0] nmag;
    logic [COEFF_W:0]   sh;
    logic               qbit;

    assign nmag = dividend[COEFF_W-1] ? -dividend : dividend;
    assign sh   = {rem_reg[COEFF_W-1:0], quo_reg[DW-1]};
    assign qbit = sh >= {1'b0, dmag_reg};
    assign done = done_reg;

    always_comb begin
        if (!neg_reg) begin
            quotient = (quo_reg > DW'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo_reg[COEFF_W-1:0];
        end else begin
            quotient = (quo_reg > DW'(33'h080000000)) ? 32'h80000000
                                                     : -quo_reg[COEFF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= DW'(nmag) << FRAC_BITS;
            dmag_reg <= divisor[COEFF_W-1] ? -divisor : divisor;
            neg_reg  <= dividend[COEFF_W-1] ^ divisor[COEFF_W-1];
        end else if (busy_reg) begin
            rem_reg <= qbit ? sh - {1'b0, dmag_reg} : sh;
            quo_reg <= {quo_reg[DW-2:0], qbit};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - QCW'(1);
                if (cnt_reg == QCW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/pau_back.sv]
// Execution side: operand and result stores, MAC sequencer, result output
// register. Depends on pau_pkg and pau_div.
module pau_back
    import pau_pkg::*;
#(
    parameter int OPERAND_TERMS = OPERAND_TERMS_DEF,
    parameter int RESULT_TERMS  = RESULT_TERMS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pau_cmd_t           cmd,
    input  pau_fifo_st_t       fifo_st,
    input  logic [MODE_W-1:0]  mode,
    input  logic [COEFF_W-1:0] scalar,
    input  logic [EXP_W-1:0]   exponent,
    output pau_back_st_t       st,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [COEFF_W-1:0] m_coeff,
    output logic [TERM_W-1:0]  m_index,
    output logic [ERR_W-1:0]   m_err,
    output logic               m_last
);

    localparam int OAW = $clog2(OPERAND_TERMS);
    localparam int OLW = $clog2(OPERAND_TERMS + 1);
    localparam int RAW = $clog2(RESULT_TERMS);
    localparam int CW  = $clog2(OPERAND_TERMS + RESULT_TERMS + 1) + 1;
    localparam logic [CW-1:0] RT_C = CW'(RESULT_TERMS);
    localparam logic [CW-1:0] C1 = CW'(1);
    localparam logic [COEFF_W-1:0] ONE = COEFF_W'(64'd1 << FRAC_BITS);

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_INIT   = 14'b00000000000010,
        S_PASS   = 14'b00000000000100,
        S_KSTART = 14'b00000000001000,
        S_RD     = 14'b00000000010000,
        S_MUL    = 14'b00000000100000,
        S_ACC    = 14'b00000001000000,
        S_DIVGO  = 14'b00000010000000,
        S_DIVW   = 14'b00000100000000,
        S_WR     = 14'b00001000000000,
        S_END    = 14'b00010000000000,
        S_ORD    = 14'b00100000000000,
        S_OLD    = 14'b01000000000000,
        S_OHOLD  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [COEFF_W-1:0] a_mem [OPERAND_TERMS];
    logic [COEFF_W-1:0] b_mem [OPERAND_TERMS];
    logic [COEFF_W-1:0] r0_mem [RESULT_TERMS];
    logic [COEFF_W-1:0] r1_mem [RESULT_TERMS];
    logic [COEFF_W-1:0] a_q, b_q, r0_q, r1_q;

    logic [OLW-1:0] nza_reg, nza_next, nzb_reg, nzb_next;
    logic [CW-1:0]  k_reg, k_next, i_reg, i_next;
    logic [CW-1:0]  src_nz_reg, src_nz_next, res_nz_reg, res_nz_next;
    logic [CW-1:0]  out_nz_reg, out_nz_next;
    logic           p_reg, p_next;
    logic [EXP_W-1:0] pcount_reg, pcount_next;
    logic signed [63:0] acc_reg, acc_next, prod_reg, prod_next;
    logic           gx_reg, gx_next, gy_reg, gy_next;
    logic           m_valid_reg, m_valid_next, m_last_reg, m_last_next;
    logic [COEFF_W-1:0] m_coeff_reg, m_coeff_next;
    logic [TERM_W-1:0]  m_index_reg, m_index_next;
    logic [ERR_W-1:0]   m_err_reg, m_err_next;

    logic is_addsub, is_mul, is_scale, is_div, is_pow, pop;
    logic [CW-1:0] la, lb, lsrc, lx, ly, n_total, hi, lo, yi, lout;
    logic [CW-1:0] a_addr, b_addr, r_addr;
    logic signed [COEFF_W-1:0] xv, yv, r_src_q, r_out_q;
    logic signed [COEFF_W:0] sum33;
    logic signed [64:0] s65;
    logic signed [63:0] acc_shr;
    logic [COEFF_W-1:0] wr_val, div_q;
    logic r_we, r_wsel, div_start, div_done;
    logic [RAW-1:0] r_waddr;
    logic [COEFF_W-1:0] r_wdata;

    assign is_addsub = mode == MODE_ADD || mode == MODE_SUB;
    assign is_mul    = mode == MODE_MUL;
    assign is_scale  = mode == MODE_SCALE;
    assign is_div    = mode == MODE_DIV;
    assign is_pow    = mode == MODE_POW;

    assign la   = (nza_reg == '0) ? C1 : CW'(nza_reg);
    assign lb   = (nzb_reg == '0) ? C1 : CW'(nzb_reg);
    assign lsrc = (src_nz_reg == '0) ? C1 : src_nz_reg;
    assign lout = (out_nz_reg == '0) ? C1 : out_nz_reg;

    always_comb begin
        if (is_addsub) begin
            lx = (la > lb) ? la : lb;
            ly = C1;
        end else if (is_mul) begin
            lx = la;
            ly = lb;
        end else if (is_pow) begin
            lx = lsrc;
            ly = la;
        end else begin
            lx = la;
            ly = C1;
        end
    end

    assign n_total = lx + ly - C1;
    assign hi      = (k_reg < lx - C1) ? k_reg : lx - C1;
    assign lo      = (k_reg + C1 > ly) ? k_reg + C1 - ly : '0;
    assign yi      = k_reg - i_reg;
    assign a_addr  = is_pow ? yi : i_reg;
    assign b_addr  = is_mul ? yi : i_reg;
    assign r_addr  = (state_reg == S_ORD) ? k_reg : i_reg;
    assign r_src_q = p_reg ? r1_q : r0_q;
    assign r_out_q = (is_pow && p_reg) ? r1_q : r0_q;

    assign pop       = (state_reg == S_IDLE) && !fifo_st.empty;
    assign st.pop    = pop;
    assign st.busy   = state_reg != S_IDLE;
    assign div_start = state_reg == S_DIVGO;

    // operand stores
    always_ff @(posedge aclk) begin
        if (pop && cmd.wr && !cmd.sel) begin
            a_mem[cmd.addr[OAW-1:0]] <= cmd.data;
        end
        if (pop && cmd.wr && cmd.sel) begin
            b_mem[cmd.addr[OAW-1:0]] <= cmd.data;
        end
        a_q <= a_mem[a_addr[OAW-1:0]];
        b_q <= b_mem[b_addr[OAW-1:0]];
    end

    // result buffers, swapped between power passes
    always_ff @(posedge aclk) begin
        if (r_we && !r_wsel) begin
            r0_mem[r_waddr] <= r_wdata;
        end
        if (r_we && r_wsel) begin
            r1_mem[r_waddr] <= r_wdata;
        end
        r0_q <= r0_mem[r_addr[RAW-1:0]];
        r1_q <= r1_mem[r_addr[RAW-1:0]];
    end

    pau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (gx_reg ? a_q : '0),
        .divisor  (scalar),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        xv = gx_reg ? (is_pow ? r_src_q : $signed(a_q)) : '0;
        if (is_scale) begin
            yv = $signed(scalar);
        end else if (is_pow) begin
            yv = gy_reg ? $signed(a_q) : '0;
        end else begin
            yv = gy_reg ? $signed(b_q) : '0;
        end
        if (mode == MODE_SUB) begin
            sum33 = {xv[COEFF_W-1], xv} - {yv[COEFF_W-1], yv};
        end else begin
            sum33 = {xv[COEFF_W-1], xv} + {yv[COEFF_W-1], yv};
        end
        s65     = {acc_reg[63], acc_reg} + {prod_reg[63], prod_reg};
        acc_shr = acc_reg >>> FRAC_BITS;
        if (is_div) begin
            wr_val = div_q;
        end else if (is_addsub) begin
            wr_val = sat32(acc_reg);
        end else begin
            wr_val = sat32(acc_shr);
        end
    end

    always_comb begin
        state_next   = state_reg;
        nza_next     = nza_reg;
        nzb_next     = nzb_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        src_nz_next  = src_nz_reg;
        res_nz_next  = res_nz_reg;
        out_nz_next  = out_nz_reg;
        p_next       = p_reg;
        pcount_next  = pcount_reg;
        acc_next     = acc_reg;
        prod_next    = prod_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        m_valid_next = m_valid_reg;
        m_coeff_next = m_coeff_reg;
        m_index_next = m_index_reg;
        m_err_next   = m_err_reg;
        m_last_next  = m_last_reg;
        r_we         = 1'b0;
        r_wsel       = is_pow ? ~p_reg : 1'b0;
        r_waddr      = k_reg[RAW-1:0];
        r_wdata      = wr_val;

        case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    nza_next = cmd.nza[OLW-1:0];
                    nzb_next = cmd.nzb[OLW-1:0];
                    if (cmd.run) begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT: begin
                k_next      = '0;
                res_nz_next = '0;
                if (is_pow) begin
                    r_we        = 1'b1;
                    r_wsel      = 1'b0;
                    r_waddr     = '0;
                    r_wdata     = ONE;
                    p_next      = 1'b0;
                    src_nz_next = C1;
                    pcount_next = '0;
                    if (exponent == '0) begin
                        out_nz_next = C1;
                        state_next  = S_ORD;
                    end else begin
                        state_next = S_PASS;
                    end
                end else if (is_div && scalar == '0) begin
                    m_valid_next = 1'b1;
                    m_coeff_next = '0;
                    m_index_next = '0;
                    m_err_next   = ERR_DIV_ZERO;
                    m_last_next  = 1'b1;
                    state_next   = S_OHOLD;
                end else if (n_total > RT_C) begin
                    m_valid_next = 1'b1;
                    m_coeff_next = '0;
                    m_index_next = '0;
                    m_err_next   = ERR_TOO_LONG;
                    m_last_next  = 1'b1;
                    state_next   = S_OHOLD;
                end else begin
                    state_next = S_KSTART;
                end
            end
            S_PASS: begin
                k_next      = '0;
                res_nz_next = '0;
                if (n_total > RT_C) begin
                    m_valid_next = 1'b1;
                    m_coeff_next = '0;
                    m_index_next = '0;
                    m_err_next   = ERR_TOO_LONG;
                    m_last_next  = 1'b1;
                    state_next   = S_OHOLD;
                end else begin
                    state_next = S_KSTART;
                end
            end
            S_KSTART: begin
                acc_next   = '0;
                i_next     = lo;
                state_next = S_RD;
            end
            S_RD: begin
                gx_next = is_pow ? (i_reg < src_nz_reg) : (i_reg < CW'(nza_reg));
                if (is_mul) begin
                    gy_next = yi < CW'(nzb_reg);
                end else if (is_pow) begin
                    gy_next = yi < CW'(nza_reg);
                end else begin
                    gy_next = i_reg < CW'(nzb_reg);
                end
                state_next = is_div ? S_DIVGO : S_MUL;
            end
            S_MUL: begin
                if (is_addsub) begin
                    prod_next = 64'(sum33);
                end else begin
                    prod_next = 64'(xv) * 64'(yv);
                end
                state_next = S_ACC;
            end
            S_ACC: begin
                if (s65[64] != s65[63]) begin
                    acc_next = s65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                end else begin
                    acc_next = s65[63:0];
                end
                if (i_reg == hi) begin
                    state_next = S_WR;
                end else begin
                    i_next     = i_reg + C1;
                    state_next = S_RD;
                end
            end
            S_DIVGO: begin
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    state_next = S_WR;
                end
            end
            S_WR: begin
                r_we = 1'b1;
                if (wr_val != '0) begin
                    res_nz_next = k_reg + C1;
                end
                if (k_reg + C1 == n_total) begin
                    state_next = S_END;
                end else begin
                    k_next     = k_reg + C1;
                    state_next = S_KSTART;
                end
            end
            S_END: begin
                k_next = '0;
                if (is_pow) begin
                    p_next      = ~p_reg;
                    src_nz_next = res_nz_reg;
                    pcount_next = pcount_reg + EXP_W'(1);
                    if ({1'b0, pcount_reg} + 7'd1 == {1'b0, exponent}) begin
                        out_nz_next = res_nz_reg;
                        state_next  = S_ORD;
                    end else begin
                        state_next = S_PASS;
                    end
                end else begin
                    out_nz_next = res_nz_reg;
                    state_next  = S_ORD;
                end
            end
            S_ORD: begin
                state_next = S_OLD;
            end
            S_OLD: begin
                m_valid_next = 1'b1;
                m_coeff_next = (k_reg < out_nz_reg) ? r_out_q : '0;
                m_index_next = k_reg[TERM_W-1:0];
                m_err_next   = ERR_NONE;
                m_last_next  = k_reg + C1 == lout;
                state_next   = S_OHOLD;
            end
            S_OHOLD: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + C1;
                        state_next = S_ORD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            nza_reg     <= '0;
            nzb_reg     <= '0;
            pcount_reg  <= '0;
            acc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            nza_reg     <= nza_next;
            nzb_reg     <= nzb_next;
            pcount_reg  <= pcount_next;
            acc_reg     <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        i_reg       <= i_next;
        src_nz_reg  <= src_nz_next;
        res_nz_reg  <= res_nz_next;
        out_nz_reg  <= out_nz_next;
        p_reg       <= p_next;
        prod_reg    <= prod_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        m_coeff_reg <= m_coeff_next;
        m_index_reg <= m_index_next;
        m_err_reg   <= m_err_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_coeff  = m_coeff_reg;
    assign m_index  = m_index_reg;
    assign m_err    = m_err_reg;
    assign m_last   = m_last_reg;

endmodule

[hdl/polynomial_arithmetic_unit.sv]
// Polynomial arithmetic unit on signed Q16.16 coefficients.
// Input words on s_*: tuser = operand select (0 A, 1 B), tdata = coefficient,
// tlast = last coefficient of that operand. The last word of the operand the
// mode needs (B for add/sub/multiply, A for scale/divide/power) starts a run.
// Result words on m_*: coefficients constant term first, tlast on the final
// one; an error (divide by zero, result too long) is one word with tuser set.
// Words go through a 4-deep command queue; the queue fills while a run is
// busy and s_tready drops only when it is full.
// Stored words are taken one per cycle while the engine is idle; a run steps
// through its MACs one at a time on the single multiply-accumulate unit,
// writing each result term in turn; divide works term by term on the
// bit-serial divider, power is exponent convolutions in a row; each output
// word waits for the receiver.
// m_tvalid holds with a stable word while m_tready is low; the engine waits.
// Reset (synchronous, aresetn low) clears control, operand lengths and the
// registers mode=add, scalar=1.0, exponent=1; stores are not cleared.
module polynomial_arithmetic_unit
    import pau_pkg::*;
#(
    parameter int OPERAND_TERMS = OPERAND_TERMS_DEF,
    parameter int RESULT_TERMS  = RESULT_TERMS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // [31:0] coeff_in
    input  logic               s_tuser,   // [0] operand_sel
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata,   // [31:0] coeff_out, [37:32] term_index
    output logic [ERR_W-1:0]   m_tuser,   // [1:0] error_code
    output logic               m_tlast,
    input  logic               cfg_we,
    input  logic [CFG_AW-1:0]  cfg_addr,
    input  logic [31:0]        cfg_wdata
);

    logic [MODE_W-1:0]  mode_reg;
    logic [COEFF_W-1:0] scalar_reg;
    logic [EXP_W-1:0]   exponent_reg;

    pau_fifo_st_t fifo_st;
    pau_back_st_t back_st;
    pau_cmd_t     push_cmd, head_cmd;
    logic         push;
    logic [COEFF_W-1:0] m_coeff;
    logic [TERM_W-1:0]  m_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_ADD;
            scalar_reg   <= 32'h00010000;
            exponent_reg <= EXP_W'(1);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MODE:     mode_reg     <= cfg_wdata[MODE_W-1:0];
                REG_SCALAR:   scalar_reg   <= cfg_wdata;
                REG_EXPONENT: exponent_reg <= cfg_wdata[EXP_W-1:0];
                default: ;
            endcase
        end
    end

    pau_front #(
        .OPERAND_TERMS (OPERAND_TERMS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_sel   (s_tuser),
        .in_coeff (s_tdata),
        .in_last  (s_tlast),
        .mode     (mode_reg),
        .fifo_st  (fifo_st),
        .push     (push),
        .cmd      (push_cmd)
    );

    pau_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (back_st.pop),
        .head     (head_cmd),
        .st       (fifo_st)
    );

    pau_back #(
        .OPERAND_TERMS (OPERAND_TERMS),
        .RESULT_TERMS  (RESULT_TERMS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (head_cmd),
        .fifo_st  (fifo_st),
        .mode     (mode_reg),
        .scalar   (scalar_reg),
        .exponent (exponent_reg),
        .st       (back_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_coeff  (m_coeff),
        .m_index  (m_index),
        .m_err    (m_tuser),
        .m_last   (m_tlast)
    );

    assign m_tdata = {2'b00, m_index, m_coeff};

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        back_st.pop |-> !fifo_st.empty)
        else $error("command popped from empty queue");

    a_out_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> back_st.busy)
        else $error("result word shown while engine idle");

    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ERR_NONE) |-> (m_tlast && m_tdata == '0))
        else $error("error word malformed");

endmodule

[tb/tb_polynomial_arithmetic_unit.sv]
// Testbench for polynomial_arithmetic_unit: random and directed operand words,
// scoreboard class predicting every result word. Depends on pau_pkg and the RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [31:0] coeff;
    logic [5:0]  idx;
    logic [1:0]  err;
    logic        last;
} poly_word_t;

class poly_scoreboard;
    int          a_store[64];
    int          b_store[64];
    int          res[64];
    int          wk[64];
    int          a_len, b_len;
    bit          a_closed, b_closed;
    logic [2:0]  mode;
    int          scalar;
    int          expo;
    poly_word_t  pending[$];
    int          errors;

    function new();
        a_len = 0; b_len = 0; a_closed = 0; b_closed = 0;
        mode = pau_pkg::MODE_ADD; scalar = 65536; expo = 1; errors = 0;
    endfunction

    function void write_reg(logic [1:0] addr, logic [31:0] data);
        if (addr == pau_pkg::REG_MODE) mode = data[2:0];
        else if (addr == pau_pkg::REG_SCALAR) scalar = data;
        else if (addr == pau_pkg::REG_EXPONENT) expo = data[5:0];
    endfunction

    function int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function longint add_sat64(longint a, longint b);
        longint mx;
        longint mn;
        mx = 64'h7FFFFFFFFFFFFFFF;
        mn = 64'h8000000000000000;
        if (a > 0 && b > mx - a) return mx;
        if (a < 0 && b < mn - a) return mn;
        return a + b;
    endfunction

    function int fetch(int s[64], int n, int i);
        return (i < n) ? s[i] : 0;
    endfunction

    function int trim_len(int s[64], int n);
        while (n > 0 && s[n-1] == 0) n--;
        return (n != 0) ? n : 1;
    endfunction

    function int convolve(int x[64], int lx, int nx, int y[64], int ly, int ny,
                          output int d[64]);
        longint acc;
        int n;
        n = lx + ly - 1;
        d = wk;
        for (int k = 0; k < n; k++) begin
            acc = 0;
            for (int i = 0; i < lx; i++) begin
                if (k >= i && k - i < ly)
                    acc = add_sat64(acc, longint'(fetch(x, nx, i)) *
                                         longint'(fetch(y, ny, k - i)));
            end
            d[k] = clamp32(acc >>> 16);
        end
        return n;
    endfunction

    function void push_error(logic [1:0] code);
        poly_word_t w;
        w.coeff = 0; w.idx = 0; w.err = code; w.last = 1;
        pending.push_back(w);
    endfunction

    function void run_poly();
        int la, lb, n, m, rl;
        longint a, b, c;
        poly_word_t w;
        la = trim_len(a_store, a_len);
        lb = trim_len(b_store, b_len);
        n = 1;
        if (mode == pau_pkg::MODE_ADD || mode == pau_pkg::MODE_SUB) begin
            n = (la > lb) ? la : lb;
            for (int k = 0; k < n; k++) begin
                a = fetch(a_store, a_len, k);
                b = fetch(b_store, b_len, k);
                res[k] = clamp32(mode == pau_pkg::MODE_ADD ? a + b : a - b);
            end
        end else if (mode == pau_pkg::MODE_MUL) begin
            if (la + lb - 1 > 64) begin push_error(pau_pkg::ERR_TOO_LONG); return; end
            n = convolve(a_store, la, a_len, b_store, lb, b_len, res);
        end else if (mode == pau_pkg::MODE_SCALE || mode == pau_pkg::MODE_DIV) begin
            if (mode == pau_pkg::MODE_DIV && scalar == 0) begin
                push_error(pau_pkg::ERR_DIV_ZERO);
                return;
            end
            n = la;
            for (int k = 0; k < n; k++) begin
                c = fetch(a_store, a_len, k);
                if (mode == pau_pkg::MODE_SCALE)
                    res[k] = clamp32((c * longint'(scalar)) >>> 16);
                else
                    res[k] = clamp32((c <<< 16) / longint'(scalar));
            end
        end else begin
            res[0] = 65536;
            n = 1;
            for (int pc = 0; pc < expo; pc++) begin
                if (n + la - 1 > 64) begin push_error(pau_pkg::ERR_TOO_LONG); return; end
                m = convolve(res, n, n, a_store, la, a_len, wk);
                for (int k = 0; k < m; k++) res[k] = wk[k];
                n = trim_len(res, m);
            end
        end
        rl = trim_len(res, n);
        for (int k = 0; k < rl; k++) begin
            w.coeff = res[k]; w.idx = k[5:0]; w.err = pau_pkg::ERR_NONE;
            w.last = (k + 1 == rl);
            pending.push_back(w);
        end
    endfunction

    function void note_word(bit sel, int c, bit last);
        if (sel) begin
            if (b_closed) begin b_len = 0; b_closed = 0; end
            if (b_len < 32) begin b_store[b_len] = c; b_len++; end
        end else begin
            if (a_closed) begin a_len = 0; a_closed = 0; end
            if (a_len < 32) begin a_store[a_len] = c; a_len++; end
        end
        if (!last) return;
        if (sel) b_closed = 1; else a_closed = 1;
        if (sel && mode <= pau_pkg::MODE_MUL) run_poly();
        if (!sel && mode >= pau_pkg::MODE_SCALE && mode <= pau_pkg::MODE_POW) run_poly();
    endfunction

    function void check_word(poly_word_t got);
        poly_word_t w;
        if (pending.size() == 0) begin
            $display("%0t unexpected word: exp none got %h", $time, got);
            errors++;
            return;
        end
        w = pending.pop_front();
        if (got.coeff !== w.coeff) begin
            $display("%0t coeff mismatch: exp %h got %h", $time, w.coeff, got.coeff);
            errors++;
        end
        if (got.idx !== w.idx) begin
            $display("%0t term index mismatch: exp %0d got %0d", $time, w.idx, got.idx);
            errors++;
        end
        if (got.err !== w.err) begin
            $display("%0t error code mismatch: exp %0d got %0d", $time, w.err, got.err);
            errors++;
        end
        if (got.last !== w.last) begin
            $display("%0t last mismatch: exp %0d got %0d", $time, w.last, got.last);
            errors++;
        end
    endfunction
endclass

module tb_polynomial_arithmetic_unit;
    import pau_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 200;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [31:0]        s_tdata = 0;
    logic               s_tuser = 0;
    logic               s_tlast = 0;
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [39:0]        m_tdata;
    logic [ERR_W-1:0]   m_tuser;
    logic               m_tlast;
    logic               cfg_we = 0;
    logic [CFG_AW-1:0]  cfg_addr = 0;
    logic [31:0]        cfg_wdata = 0;

    poly_scoreboard sb = new();
    int  words_sent = 0;
    int  hold_req = 0;
    bit  no_idle = 0;

    polynomial_arithmetic_unit u_top (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int rand_coeff(int style);
        int r;
        r = $urandom_range(0, 4);
        case (style)
            0: return (int'($urandom_range(0, 8)) - 4) * 65536 + int'($urandom_range(0, 255));
            1: return $urandom;
            default: begin
                case (r)
                    0: return 32'h7FFFFFFF;
                    1: return 32'h80000000;
                    2: return 0;
                    3: return 65536;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
        cfg_we <= 1; cfg_addr <= addr; cfg_wdata <= data;
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
        sb.write_reg(addr, data);
    endtask

    task automatic wait_idle();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic send_word(bit sel, int c, bit last);
        int r, gap;
        r = $urandom_range(0, 99);
        gap = no_idle ? 0 : (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 60);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1; s_tuser <= sel; s_tdata <= c; s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_word(sel, c, last);
        words_sent++;
    endtask

    task automatic send_poly(bit sel, int len, int style);
        bit zero_tail;
        zero_tail = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < len; i++)
            send_word(sel, (zero_tail && i > 0 && i >= len - 2) ? 0 : rand_coeff(style),
                      i == len - 1);
    endtask

    task automatic set_config(logic [2:0] m, int sc, int ex);
        cfg_write(REG_MODE, ($urandom & 32'hFFFFFFF8) | m);
        cfg_write(REG_SCALAR, sc);
        cfg_write(REG_EXPONENT, ($urandom & 32'hFFFFFFC0) | ex);
    endtask

    // receiver
    initial begin
        int stall, r;
        poly_word_t got;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.coeff = m_tdata[31:0]; got.idx = m_tdata[37:32];
                got.err = m_tuser; got.last = m_tlast;
                sb.check_word(got);
            end
            if (hold_req > 0) begin
                stall = hold_req; hold_req = 0;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 0;
            end else if (no_idle) begin
                m_tready <= 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) m_tready <= 1;
                else begin
                    m_tready <= 0;
                    stall = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 80);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int run_no, r, len, sc, ex;
        logic [2:0] m;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: saturation, each mode, zero divisor, too long, unused modes
        send_word(0, 32'h7FFFFFFF, 0); send_word(0, 32'h80000000, 1);
        send_word(1, 32'h7FFFFFFF, 0); send_word(1, 32'h80000000, 1);
        send_word(1, 0, 1);
        wait_idle(); set_config(MODE_SUB, 65536, 1);
        send_word(1, 1, 0); send_word(1, 0, 0); send_word(1, 0, 1);
        wait_idle(); cfg_write(REG_MODE, MODE_MUL);
        send_word(1, 32'h80000000, 1);
        wait_idle(); set_config(MODE_SCALE, 32'h80000000, 1);
        send_word(0, 32'h80000000, 0); send_word(0, 65536, 1);
        wait_idle(); set_config(MODE_DIV, 0, 1);
        send_word(0, 5, 1);
        wait_idle(); cfg_write(REG_SCALAR, -1);
        send_word(0, 32'h80000000, 1);
        wait_idle(); set_config(MODE_POW, 65536, 0);
        send_word(0, 3 * 65536, 1);
        wait_idle(); cfg_write(REG_EXPONENT, 40);
        send_word(0, 65536, 0); send_word(0, 65536, 0); send_word(0, 65536, 1);
        wait_idle(); cfg_write(REG_MODE, 3'd6); cfg_write(2'd3, $urandom);
        send_word(0, 1, 1); send_word(1, 1, 1);
        wait_idle();

        // random
        run_no = 0;
        while (words_sent < 425) begin
            if (run_no % 12 == 0) begin
                wait_idle();
                r = $urandom_range(0, 7);
                case (r)
                    0: sc = 0; 1: sc = -1; 2: sc = 32'h7FFFFFFF; 3: sc = 32'h80000000;
                    4: sc = 65536; default: sc = $urandom;
                endcase
                r = $urandom_range(0, 9);
                ex = (r < 6) ? r : (r < 8) ? 63 : $urandom_range(0, 63);
                m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
                set_config(m, sc, ex);
                no_idle = ($urandom_range(0, 4) == 0);
            end
            if (run_no == 30) hold_req = 3000;
            r = $urandom_range(0, 99);
            len = (r < 85) ? $urandom_range(1, 4) : (r < 97) ? $urandom_range(5, 12)
                                                       : $urandom_range(30, 35);
            if (m == MODE_POW && ex > 8) len = $urandom_range(1, 3);
            if ($urandom_range(0, 9) == 0) send_word($urandom_range(0, 1), $urandom, 0);
            if (m <= MODE_MUL || m > MODE_POW) begin
                send_poly(0, len, $urandom_range(0, 2));
                send_poly(1, (r < 85) ? $urandom_range(1, 4) : len, $urandom_range(0, 2));
            end else begin
                if ($urandom_range(0, 4) == 0) send_poly(1, $urandom_range(1, 3), 1);
                send_poly(0, len, $urandom_range(0, 2));
            end
            run_no++;
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
hdl/pau_pkg.sv
hdl/pau_front.sv
hdl/pau_cmd_fifo.sv
hdl/pau_div.sv
hdl/pau_back.sv
hdl/polynomial_arithmetic_unit.sv
tb/tb_polynomial_arithmetic_unit.sv
